// ===== sv/lzfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared types, result codes and frame constants for the LZ4 frame deframer.
// ----------------------------------------------------------------------------
package lzfd_pkg;

	// result kinds
	localparam logic [2:0] KIND_RAW       = 3'd0;
	localparam logic [2:0] KIND_COMP      = 3'd1;
	localparam logic [2:0] KIND_BLOCK_CK  = 3'd2;
	localparam logic [2:0] KIND_CONTENT_CK = 3'd3;
	localparam logic [2:0] KIND_DONE      = 3'd4;
	localparam logic [2:0] KIND_ERROR     = 3'd5;

	// error codes
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_SHORT_HDR   = 4'd1;
	localparam logic [3:0] ERR_BAD_MAGIC   = 4'd2;
	localparam logic [3:0] ERR_DEPENDENT   = 4'd3;
	localparam logic [3:0] ERR_DICT_ID     = 4'd4;
	localparam logic [3:0] ERR_BAD_BD      = 4'd5;
	localparam logic [3:0] ERR_OVERSIZE    = 4'd6;
	localparam logic [3:0] ERR_TRUNCATED   = 4'd7;
	localparam logic [3:0] ERR_CCK_MISSING = 4'd8;

	// frame format constants
	localparam logic [31:0] MAGIC_WORD = 32'h184D2204;
	localparam int          RAW_BIT    = 31;
	localparam logic [7:0]  FLG_INDEP  = 8'h20;
	localparam logic [7:0]  FLG_DICT   = 8'h03;
	localparam logic [7:0]  FLG_BCK    = 8'h10;
	localparam logic [7:0]  FLG_CCK    = 8'h04;
	localparam logic [7:0]  BD_MASK    = 8'h70;
	localparam int          BLOCK_BASE = 64 * 1024;
	localparam int          SIZE_W     = 31;
	localparam int          REM_W      = 23;

	// result queue
	localparam int QDEPTH  = 4;
	localparam int QIDX_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [31:0] check_word;
		logic        block_end;
		logic [3:0]  error_code;
	} result_t;

	// up to two results from one input beat, in order
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	localparam result_t NO_RES = '{kind: KIND_RAW, data_byte: 8'd0, check_word: 32'd0,
		block_end: 1'b0, error_code: ERR_NONE};

	function automatic result_t res_err(input logic [3:0] code);
		result_t r;
		r = NO_RES;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t res_done();
		result_t r;
		r = NO_RES;
		r.kind = KIND_DONE;
		return r;
	endfunction

	function automatic result_t res_data(input logic raw, input logic [7:0] b,
		input logic last_byte);
		result_t r;
		r = NO_RES;
		r.kind = raw ? KIND_RAW : KIND_COMP;
		r.data_byte = b;
		r.block_end = last_byte;
		return r;
	endfunction

	function automatic result_t res_word(input logic [2:0] k, input logic [31:0] w);
		result_t r;
		r = NO_RES;
		r.kind = k;
		r.check_word = w;
		return r;
	endfunction

endpackage

// ===== sv/lzfd_result_queue.sv =====
// ----------------------------------------------------------------------------
// lzfd_result_queue
// Small in-order result queue; slot zero is the registered output.
// ----------------------------------------------------------------------------
module lzfd_result_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  lzfd_pkg::push_t push,
	input  logic            pop,
	output lzfd_pkg::result_t head,
	output logic            head_valid,
	output logic            room
);
	import lzfd_pkg::*;

	result_t            q_q [QDEPTH];
	result_t            q_d [QDEPTH];
	logic [QCNT_W-1:0]  cnt_q;
	logic [QCNT_W-1:0]  base;

	always_comb begin
		base = cnt_q - QCNT_W'(pop);
		for (int i = 0; i < QDEPTH; i++) begin
			if (QCNT_W'(i) < base) begin
				q_d[i] = q_q[QIDX_W'(i) + QIDX_W'(pop)];
			end else if (QCNT_W'(i) == base && push.cnt != 2'd0) begin
				q_d[i] = push.r0;
			end else if (QCNT_W'(i) == base + QCNT_W'(1) && push.cnt == 2'd2) begin
				q_d[i] = push.r1;
			end else begin
				q_d[i] = q_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + QCNT_W'(push.cnt);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			q_q[i] <= q_d[i];
		end
	end

	assign head       = q_q[0];
	assign head_valid = (cnt_q != '0);
	// hold off the parser unless two free slots remain
	assign room       = (cnt_q <= QCNT_W'(QDEPTH - 2));

endmodule

// ===== sv/lz4_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// lz4_frame_deframer_top
// A result passes through the input register and a result-queue slot before it reaches the outputs.
// Throughput: one frame byte per cycle while the queue has two free slots; a beat
//   that yields two results (data byte or checksum plus status) fills two slots.
// The output queue holds four results and the parser stalls below two free.
// Reset: arst_n clears the parser to the header phase and empties the queue.
// ----------------------------------------------------------------------------
module lz4_frame_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [31:0] check_word,
	output logic        block_end,
	output logic [3:0]  error_code
);
	import lzfd_pkg::*;

	// parser phases
	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_SIZE = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_BCK  = 3'd3;
	localparam logic [2:0] PH_CCK  = 3'd4;
	localparam logic [2:0] PH_IDLE = 3'd5;

	// input register stage
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// parser state
	logic [2:0]        ph_q, ph_d;
	logic [2:0]        fc_q, fc_d;
	logic [23:0]       word_q, word_d;
	logic [47:0]       hdr_q, hdr_d;
	logic              bc_q, bc_d;
	logic              cc_q, cc_d;
	logic [1:0]        code_q, code_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic              raw_q, raw_d;

	push_t   push, push_gated;
	result_t head;
	logic    room;
	logic    adv;
	logic    in_acc;

	// derived values for the current beat
	logic [31:0]       word_full;
	logic              word_done;
	logic [SIZE_W-1:0] blk_size;
	logic [SIZE_W-1:0] max_size;
	logic [7:0]        flg;
	logic [7:0]        bd;
	logic              last_byte;
	logic [REM_W-1:0]  rem_dec;
	result_t           over_res;

	// Advance the parser only when the queue can take both possible results.
	assign adv      = v_s1 && room;
	assign in_ready = !v_s1 || room;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Size words and checksum words arrive little-endian; the fourth byte
	// completes the word straight from the input register.
	assign word_full = {byte_s1, word_q};
	assign word_done = (fc_q[1:0] == 2'd3);
	assign blk_size  = word_full[SIZE_W-1:0];
	assign max_size  = SIZE_W'(BLOCK_BASE) << {code_q, 1'b0};
	assign flg       = hdr_q[39:32];
	assign bd        = hdr_q[47:40];
	assign rem_dec   = rem_q - REM_W'(1);
	assign last_byte = (rem_dec == '0);
	// end of buffer where the frame may legally stop
	assign over_res  = (cc_q && !bc_q) ? res_err(ERR_CCK_MISSING) : res_done();

	always_comb begin
		ph_d   = ph_q;
		fc_d   = fc_q;
		word_d = word_q;
		hdr_d  = hdr_q;
		bc_d   = bc_q;
		cc_d   = cc_q;
		code_d = code_q;
		rem_d  = rem_q;
		raw_d  = raw_q;
		push.cnt = 2'd0;
		push.r0  = NO_RES;
		push.r1  = NO_RES;

		unique case (ph_q)
			PH_HDR: begin
				if (fc_q < 3'd6) begin
					hdr_d[{fc_q, 3'b000} +: 8] = byte_s1;
					fc_d = fc_q + 3'd1;
					if (last_s1) begin
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_SHORT_HDR);
					end
				end else begin
					// HC byte: check the header in priority order
					fc_d = 3'd0;
					priority if (hdr_q[31:0] != MAGIC_WORD) begin
						ph_d = PH_IDLE;
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_BAD_MAGIC);
					end else if ((flg & FLG_INDEP) == 8'h00) begin
						ph_d = PH_IDLE;
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_DEPENDENT);
					end else if ((flg & FLG_DICT) != 8'h00) begin
						ph_d = PH_IDLE;
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_DICT_ID);
					end else if ((bd & BD_MASK & 8'h40) == 8'h00) begin
						ph_d = PH_IDLE;
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_BAD_BD);
					end else begin
						bc_d   = ((flg & FLG_BCK) != 8'h00);
						cc_d   = ((flg & FLG_CCK) != 8'h00);
						code_d = bd[5:4];
						ph_d   = PH_SIZE;
						if (last_s1) begin
							push.cnt = 2'd1;
							push.r0  = (((flg & FLG_CCK) != 8'h00) && ((flg & FLG_BCK) == 8'h00))
								? res_err(ERR_CCK_MISSING) : res_done();
						end
					end
				end
			end
			PH_SIZE: begin
				if (word_done) begin
					fc_d = 3'd0;
					priority if (word_full == 32'd0) begin
						// end mark
						if (cc_q && !bc_q) begin
							ph_d = PH_CCK;
							if (last_s1) begin
								push.cnt = 2'd1;
								push.r0  = res_err(ERR_CCK_MISSING);
							end
						end else begin
							ph_d = PH_IDLE;
							push.cnt = 2'd1;
							push.r0  = res_done();
						end
					end else if (blk_size > max_size) begin
						ph_d = PH_IDLE;
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_OVERSIZE);
					end else if (blk_size == '0) begin
						// empty raw block: no payload beats
						if (bc_q) begin
							ph_d = PH_BCK;
							if (last_s1) begin
								push.cnt = 2'd1;
								push.r0  = res_err(ERR_TRUNCATED);
							end
						end else if (last_s1) begin
							ph_d = PH_IDLE;
							push.cnt = 2'd1;
							push.r0  = over_res;
						end
					end else begin
						raw_d = word_full[RAW_BIT];
						rem_d = blk_size[REM_W-1:0];
						ph_d  = PH_DATA;
						if (last_s1) begin
							push.cnt = 2'd1;
							push.r0  = res_err(ERR_TRUNCATED);
						end
					end
				end else begin
					word_d[{fc_q[1:0], 3'b000} +: 8] = byte_s1;
					fc_d = fc_q + 3'd1;
					if (last_s1) begin
						ph_d = PH_IDLE;
						push.cnt = 2'd1;
						push.r0  = over_res;
					end
				end
			end
			PH_DATA: begin
				rem_d = rem_dec;
				push.cnt = 2'd1;
				push.r0  = res_data(raw_q, byte_s1, last_byte);
				if (last_byte) begin
					fc_d = 3'd0;
					if (bc_q) begin
						ph_d = PH_BCK;
						if (last_s1) begin
							push.cnt = 2'd2;
							push.r1  = res_err(ERR_TRUNCATED);
						end
					end else begin
						ph_d = PH_SIZE;
						if (last_s1) begin
							push.cnt = 2'd2;
							push.r1  = over_res;
						end
					end
				end else if (last_s1) begin
					push.cnt = 2'd2;
					push.r1  = res_err(ERR_TRUNCATED);
				end
			end
			PH_BCK: begin
				if (word_done) begin
					fc_d = 3'd0;
					ph_d = PH_SIZE;
					push.cnt = 2'd1;
					push.r0  = res_word(KIND_BLOCK_CK, word_full);
					if (last_s1) begin
						push.cnt = 2'd2;
						push.r1  = over_res;
					end
				end else begin
					word_d[{fc_q[1:0], 3'b000} +: 8] = byte_s1;
					fc_d = fc_q + 3'd1;
					if (last_s1) begin
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_TRUNCATED);
					end
				end
			end
			PH_CCK: begin
				if (word_done) begin
					fc_d = 3'd0;
					ph_d = PH_IDLE;
					push.cnt = 2'd2;
					push.r0  = res_word(KIND_CONTENT_CK, word_full);
					push.r1  = res_done();
				end else begin
					word_d[{fc_q[1:0], 3'b000} +: 8] = byte_s1;
					fc_d = fc_q + 3'd1;
					if (last_s1) begin
						push.cnt = 2'd1;
						push.r0  = res_err(ERR_CCK_MISSING);
					end
				end
			end
			default: begin
				// idle: drop bytes until the buffer ends
			end
		endcase

		// buffer end: start over with a fresh frame
		if (last_s1) begin
			ph_d   = PH_HDR;
			fc_d   = 3'd0;
			bc_d   = 1'b0;
			cc_d   = 1'b0;
			code_d = 2'd0;
			rem_d  = '0;
			raw_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HDR;
			fc_q   <= 3'd0;
			bc_q   <= 1'b0;
			cc_q   <= 1'b0;
			code_q <= 2'd0;
			rem_q  <= '0;
			raw_q  <= 1'b0;
		end else if (adv) begin
			ph_q   <= ph_d;
			fc_q   <= fc_d;
			bc_q   <= bc_d;
			cc_q   <= cc_d;
			code_q <= code_d;
			rem_q  <= rem_d;
			raw_q  <= raw_d;
		end
	end

	// header bytes and partial words are fully rewritten before use
	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word_d;
			hdr_q  <= hdr_d;
		end
	end

	always_comb begin
		push_gated = push;
		if (!adv) begin
			push_gated.cnt = 2'd0;
		end
	end

	lzfd_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_gated),
		.pop        (out_valid && out_ready),
		.head       (head),
		.head_valid (out_valid),
		.room       (room)
	);

	assign kind       = head.kind;
	assign data_byte  = head.data_byte;
	assign check_word = head.check_word;
	assign block_end  = head.block_end;
	assign error_code = head.error_code;

	// buffer end always returns the parser to a clean header phase
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> ph_q == PH_HDR && fc_q == 3'd0)
		else $error("parser did not restart after buffer end");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_HDR |-> fc_q <= 3'd6)
		else $error("header byte count overran");

	a_payload_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_DATA |-> rem_q != '0)
		else $error("payload phase with nothing remaining");

	a_payload_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ph_q == PH_DATA |-> push.cnt != 2'd0)
		else $error("payload beat produced no result");

endmodule
